// File: hw/rtl/bve_pkg.sv
// Package for the bounded vector engine: item structs, operation and status codes.
// Used by bounded_vector_engine; depends on nothing.
package bve_pkg;

  localparam int BVE_DEPTH = 256;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_GET    = 3'd2;
  localparam logic [2:0] OP_SET    = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } bve_status_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  index;
    logic [63:0] value;
  } bve_in_item_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic [8:0]  fill_count;
    logic [1:0]  status;
  } bve_out_item_t;

endpackage

// File: hw/rtl/bounded_vector_engine.sv
// Bounded vector engine: fixed-capacity vector of 64-bit words in a memory with one read and one write port.
// Depends on bve_pkg for item structs and operation/status codes.
//
// Each item is accepted in idle and hands its result to the output register from finish;
// push, pop, get, set and unused kinds go from idle straight to finish. Delete moves every
// live word above the index down one place through the memory's one read and one write per
// cycle, a read and a write for each word. The input is stalled while an item is in
// progress; a finished result waits in the output register while the next item is accepted.
// Entries hold no reset value and need no clearing pass.
module bounded_vector_engine
  import bve_pkg::*;
#(
  parameter int DEPTH = BVE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bve_in_item_t  in_item,
  output logic          out_valid,
  input  logic          out_stall,
  output bve_out_item_t out_item
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 9) ? CW : 9;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SHIFT  = 4'b0010,
    ST_MOVE   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  bve_status_t   st_r, st_nxt;
  logic          rdsel_r, rdsel_nxt;
  logic          out_valid_r, out_valid_nxt;
  bve_out_item_t out_item_r;

  logic [63:0]   mem [DEPTH];
  logic [63:0]   rd_data_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_wdata;

  logic            accept, load;
  logic [CMPW-1:0] idx_ext, cnt_ext;
  logic            idx_ok;
  logic [CW-1:0]   cnt_dec, ptr_inc;
  logic [AW-1:0]   idx_addr;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign idx_ext  = CMPW'(in_item.index);
  assign cnt_ext  = CMPW'(count_r);
  assign idx_ok   = idx_ext < cnt_ext;
  assign idx_addr = AW'(idx_ext);
  assign cnt_dec  = count_r - 1'b1;
  assign ptr_inc  = CW'(ptr_r) + 1'b1;
  assign load     = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    st_nxt    = st_r;
    rdsel_nxt = rdsel_r;
    mem_we    = 1'b0;
    mem_waddr = ptr_r;
    mem_wdata = rd_data_r;
    mem_re    = 1'b0;
    mem_raddr = ptr_inc[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          st_nxt    = STAT_OK;
          rdsel_nxt = 1'b0;
          state_nxt = ST_FINISH;
          case (in_item.kind)
            OP_PUSH: begin
              if (count_r == CW'(DEPTH)) begin
                st_nxt = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = in_item.value;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                st_nxt = STAT_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cnt_dec[AW-1:0];
                rdsel_nxt = 1'b1;
                count_nxt = cnt_dec;
              end
            end
            OP_GET: begin
              if (!idx_ok) begin
                st_nxt = STAT_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = idx_addr;
                rdsel_nxt = 1'b1;
              end
            end
            OP_SET: begin
              if (!idx_ok) begin
                st_nxt = STAT_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = idx_addr;
                mem_wdata = in_item.value;
              end
            end
            OP_DELETE: begin
              if (!idx_ok) begin
                st_nxt = STAT_RANGE;
              end else begin
                ptr_nxt   = idx_addr;
                state_nxt = ST_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        if (ptr_inc < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_inc[AW-1:0];
          state_nxt = ST_MOVE;
        end else begin
          count_nxt = cnt_dec;
          state_nxt = ST_FINISH;
        end
      end
      ST_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = rd_data_r;
        ptr_nxt   = ptr_inc[AW-1:0];
        state_nxt = ST_SHIFT;
      end
      ST_FINISH: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    st_r    <= st_nxt;
    rdsel_r <= rdsel_nxt;
    if (load) begin
      out_item_r.read_value <= rdsel_r ? rd_data_r : 64'd0;
      out_item_r.fill_count <= cnt_ext[8:0];
      out_item_r.status     <= st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count above capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.kind == OP_PUSH && count_r != CW'(DEPTH))
      |=> count_r == $past(count_r) + 1'b1)
    else $error("push did not grow the vector");

  a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result loaded outside finish");

  a_move_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOVE) |-> (ptr_inc < count_r))
    else $error("delete shift past live entries");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && !(ptr_inc < count_r)) |=> count_r == $past(count_r) - 1'b1)
    else $error("delete did not shrink the vector");

endmodule

// File: dv/bounded_vector_engine_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for bounded_vector_engine: directed, then random push, pop, get, set,
// delete and unused-kind items, each result checked against an untimed model of the vector.
// Depends on bve_pkg and the bounded_vector_engine RTL.
module bounded_vector_engine_tb;
  import bve_pkg::*;

  localparam int DEPTH       = BVE_DEPTH;
  localparam int RAND_ITEMS  = 240;
  localparam int BURST_AT    = 200;
  localparam int HOLD_EVERY  = 150;
  localparam int IDLE_PCT    = 27;
  localparam int CALM_LO     = 300;
  localparam int CALM_HI     = 450;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    bve_in_item_t item;
    bit           hold;
  } pending_item_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  bve_in_item_t  in_item;
  logic          out_valid;
  logic          out_stall;
  bve_out_item_t out_item;

  pending_item_t pending_q[$];
  bve_out_item_t result_q[$];

  logic [63:0] vec_words [DEPTH];
  int          vec_count   = 0;
  int          gen_count   = 0;
  int          items_taken = 0;
  int          mismatches  = 0;
  int          cycles      = 0;
  logic        in_fire     = 1'b0;
  logic        calm;

  bounded_vector_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_stall = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  function automatic bve_out_item_t vec_apply(bve_in_item_t it);
    bve_out_item_t r;
    int i;
    r.read_value = '0;
    r.status     = STAT_OK;
    case (it.kind)
      OP_PUSH: begin
        if (vec_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          vec_words[vec_count] = it.value;
          vec_count++;
        end
      end
      OP_POP: begin
        if (vec_count == 0) begin
          r.status = STAT_RANGE;
        end else begin
          vec_count--;
          r.read_value = vec_words[vec_count];
        end
      end
      OP_GET: begin
        if (int'(it.index) >= vec_count) r.status = STAT_RANGE;
        else r.read_value = vec_words[it.index];
      end
      OP_SET: begin
        if (int'(it.index) >= vec_count) r.status = STAT_RANGE;
        else vec_words[it.index] = it.value;
      end
      OP_DELETE: begin
        if (int'(it.index) >= vec_count) begin
          r.status = STAT_RANGE;
        end else begin
          for (i = int'(it.index); i + 1 < vec_count; i++) vec_words[i] = vec_words[i + 1];
          vec_count--;
        end
      end
      default: ;
    endcase
    r.fill_count = 9'(vec_count);
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Queues one item and tracks the fill level the vector will have after it.
  task automatic queue_op(logic [2:0] kind, int idx, logic [63:0] val, bit hold = 1'b0);
    pending_item_t p;
    p.item.kind  = kind;
    p.item.index = idx[7:0];
    p.item.value = val;
    p.hold       = hold;
    pending_q.push_back(p);
    case (kind)
      OP_PUSH:   if (gen_count < DEPTH) gen_count++;
      OP_POP:    if (gen_count > 0) gen_count--;
      OP_DELETE: if (idx < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  function automatic int live_index();
    if (gen_count == 0) return $urandom_range(0, 255);
    return $urandom_range(0, (gen_count > 256 ? 256 : gen_count) - 1);
  endfunction

  assign calm = (items_taken >= CALM_LO) && (items_taken < CALM_HI);

  // Driver
  always @(negedge clk) begin
    pending_item_t nxt;
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_q.size() != 0 && pending_q[0].hold && result_q.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = pending_q.pop_front();
        in_valid <= 1'b1;
        in_item  <= nxt.item;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Monitor and predictor
  always @(posedge clk) begin
    bve_out_item_t want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result: got value %h count %0d status %0d", $time,
                 out_item.read_value, out_item.fill_count, out_item.status);
        mismatches++;
      end else begin
        want = result_q.pop_front();
        if (out_item !== want) begin
          $display({"%0t: mismatch: expected value %h count %0d status %0d, ",
                    "got value %h count %0d status %0d"},
                   $time, want.read_value, want.fill_count, want.status,
                   out_item.read_value, out_item.fill_count, out_item.status);
          mismatches++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      result_q.push_back(vec_apply(in_item));
      items_taken++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bounded_vector_engine regression: fail");
      $finish;
    end
  end

  initial begin
    int  pick;
    int  idx;
    bit  hold;
    // empty vector: every access is out of range
    queue_op(OP_POP, 0, '0);
    queue_op(OP_GET, 0, '0);
    queue_op(OP_SET, 0, '1);
    queue_op(OP_DELETE, 0, '0);
    queue_op(OP_PUSH, 0, '0);
    queue_op(OP_PUSH, 255, '1);
    queue_op(OP_PUSH, 0, 64'h5555_5555_5555_5555);
    queue_op(OP_PUSH, 170, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_op(OP_GET, 0, '0);
    queue_op(OP_GET, 3, '1);
    queue_op(OP_GET, 4, '0);
    queue_op(OP_GET, 255, '0);
    queue_op(OP_SET, 1, rand_word());
    queue_op(OP_SET, 4, rand_word());
    queue_op(OP_DELETE, 1, '0);
    queue_op(OP_DELETE, 2, '0);
    queue_op(OP_DELETE, 3, '0);
    queue_op(OP_DELETE + 3'd1, 255, '1);
    queue_op(OP_DELETE + 3'd2, $urandom_range(0, 255), rand_word());
    queue_op(OP_DELETE + 3'd3, 0, '0);
    queue_op(OP_POP, 0, '0);
    queue_op(OP_POP, 255, '1);
    queue_op(OP_POP, 0, '0);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      hold = (n % HOLD_EVERY == 0);
      if (n == BURST_AT) begin
        // fill to capacity, hit the top entry, then drain most of it back out
        queue_op(OP_PUSH, 0, rand_word(), 1'b1);
        while (gen_count < DEPTH) queue_op(OP_PUSH, $urandom_range(0, 255), rand_word());
        queue_op(OP_PUSH, $urandom_range(0, 255), rand_word());
        queue_op(OP_PUSH, $urandom_range(0, 255), rand_word());
        queue_op(OP_GET, DEPTH - 1, rand_word());
        queue_op(OP_SET, DEPTH - 1, rand_word());
        queue_op(OP_GET, DEPTH - 1, rand_word());
        queue_op(OP_DELETE, 0, rand_word());
        queue_op(OP_GET, DEPTH - 1, rand_word());
        queue_op(OP_PUSH, 0, rand_word());
        queue_op(OP_DELETE, DEPTH - 1, rand_word());
        queue_op(OP_GET, DEPTH - 2, rand_word());
        while (gen_count > 64) queue_op(OP_POP, $urandom_range(0, 255), rand_word());
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        queue_op(OP_PUSH, $urandom_range(0, 255), rand_word(), hold);
      end else if (pick < 42) begin
        queue_op(OP_POP, $urandom_range(0, 255), rand_word(), hold);
      end else if (pick < 60) begin
        queue_op(OP_GET, live_index(), rand_word(), hold);
      end else if (pick < 75) begin
        queue_op(OP_SET, live_index(), rand_word(), hold);
      end else if (pick < 85) begin
        queue_op(OP_DELETE, live_index(), rand_word(), hold);
      end else if (pick < 92) begin
        if (gen_count == 0) begin
          queue_op(OP_POP, $urandom_range(0, 255), rand_word(), hold);
        end else if (gen_count < 256) begin
          idx = $urandom_range(gen_count, 255);
          queue_op(OP_GET + 3'($urandom_range(0, 2)), idx, rand_word(), hold);
        end else begin
          queue_op(OP_PUSH, $urandom_range(0, 255), rand_word(), hold);
        end
      end else if (pick < 96) begin
        queue_op(3'($urandom_range(OP_DELETE + 1, 7)), $urandom_range(0, 255), rand_word(), hold);
      end else begin
        queue_op(3'($urandom_range(0, 7)), $urandom_range(0, 255), rand_word(), hold);
      end
    end

    while (pending_q.size() != 0 || in_valid) @(negedge clk);
    while (result_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("bounded_vector_engine regression: pass");
    end else begin
      $display("bounded_vector_engine regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/bve_pkg.sv
hw/rtl/bounded_vector_engine.sv
dv/bounded_vector_engine_tb.sv
